### design/ltc_pkg.sv
// Shared types and constants for the linear threshold classifier.
package ltc_pkg;

  localparam int MaxAttrDef    = 64;
  localparam int WeightBitsDef = 16;

  localparam int VAL_W   = 16;
  localparam int CFG_W   = 7;
  localparam int SUM_W   = 40;
  localparam int SCORE_W = 32;
  localparam int CMD_W   = 3;

  localparam logic [CFG_W-1:0] ATTR_USED_RESET = CFG_W'(64);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLASSIFY = 3'd0,
    CMD_SET      = 3'd1,
    CMD_ADD      = 3'd2,
    CMD_SUB      = 3'd3,
    CMD_MUL      = 3'd4
  } cmd_e;

  typedef struct packed {
    logic valid;
    logic acc;
    logic last;
  } acc_ctrl_t;

endpackage

### design/ltc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ltc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ltc_weight_unit.sv
// Weight lookup with write forwarding, weight update and product stage.
module ltc_weight_unit #(
  parameter int MAX_ATTR    = ltc_pkg::MaxAttrDef,
  parameter int WEIGHT_BITS = ltc_pkg::WeightBitsDef,
  localparam int IDX_W  = $clog2(MAX_ATTR + 1),
  localparam int ADDR_W = (MAX_ATTR > 1) ? $clog2(MAX_ATTR) : 1,
  localparam int PROD_W = WEIGHT_BITS + ltc_pkg::VAL_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           req_valid_i,
  input  ltc_pkg::cmd_e                  req_cmd_i,
  input  logic [IDX_W-1:0]               req_idx_i,
  input  logic signed [ltc_pkg::VAL_W-1:0] req_val_i,
  input  logic                           req_last_i,
  input  logic [ltc_pkg::CFG_W-1:0]      attr_used_i,
  output logic                           ram_re_o,
  output logic [ADDR_W-1:0]              ram_raddr_o,
  output logic                           ram_we_o,
  output logic [ADDR_W-1:0]              ram_waddr_o,
  output logic [WEIGHT_BITS-1:0]         ram_wdata_o,
  input  logic [WEIGHT_BITS-1:0]         ram_rdata_i,
  output logic signed [WEIGHT_BITS-1:0]  bias_o,
  output ltc_pkg::acc_ctrl_t             s2_ctrl_o,
  output logic signed [PROD_W-1:0]       s2_prod_o
);
  import ltc_pkg::*;

  localparam int UPD_W = PROD_W + 1;
  localparam int CMP_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;
  localparam logic [IDX_W-1:0] BIAS_IDX = IDX_W'(MAX_ATTR);
  localparam logic signed [UPD_W-1:0] W_HI =
    {{(UPD_W - WEIGHT_BITS + 1){1'b0}}, {(WEIGHT_BITS - 1){1'b1}}};
  localparam logic signed [UPD_W-1:0] W_LO = ~W_HI;

  logic                          s1_valid_q;
  cmd_e                          s1_cmd_q;
  logic [IDX_W-1:0]              s1_idx_q;
  logic signed [VAL_W-1:0]       s1_val_q;
  logic                          s1_last_q;
  logic                          fwd_hit_q;
  logic signed [WEIGHT_BITS-1:0] fwd_q;
  logic                          rd_vld_q;
  logic [MAX_ATTR-1:0]           valid_q;
  logic signed [WEIGHT_BITS-1:0] bias_q;
  acc_ctrl_t                     s2_ctrl_q;
  logic signed [PROD_W-1:0]      s2_prod_q;

  logic                          rd_in_range;
  logic                          is_bias;
  logic signed [WEIGHT_BITS-1:0] w_ram;
  logic signed [WEIGHT_BITS-1:0] w_cur;
  logic signed [PROD_W-1:0]      prod;
  logic signed [UPD_W-1:0]       upd;
  logic signed [WEIGHT_BITS-1:0] upd_sat;
  logic                          is_wcmd;
  logic                          wr_ok;
  logic                          acc_ok;
  acc_ctrl_t                     s2_ctrl_d;

  // request side: read the weight while the request enters stage 1
  assign rd_in_range = req_idx_i < BIAS_IDX;
  assign ram_re_o    = en_i;
  assign ram_raddr_o = req_idx_i[ADDR_W-1:0];

  // stage 1
  assign is_bias = s1_idx_q == BIAS_IDX;
  assign w_ram   = fwd_hit_q ? fwd_q : (rd_vld_q ? $signed(ram_rdata_i) : '0);
  assign w_cur   = is_bias ? bias_q : w_ram;
  assign prod    = w_cur * s1_val_q;

  always_comb begin
    upd     = '0;
    is_wcmd = 1'b0;
    case (s1_cmd_q)
      CMD_SET: begin
        upd     = UPD_W'(s1_val_q);
        is_wcmd = 1'b1;
      end
      CMD_ADD: begin
        upd     = UPD_W'(w_cur) + UPD_W'(s1_val_q);
        is_wcmd = 1'b1;
      end
      CMD_SUB: begin
        upd     = UPD_W'(w_cur) - UPD_W'(s1_val_q);
        is_wcmd = 1'b1;
      end
      CMD_MUL: begin
        upd     = UPD_W'(prod >>> 8);
        is_wcmd = 1'b1;
      end
      default: begin
        upd     = '0;
        is_wcmd = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (upd > W_HI) begin
      upd_sat = W_HI[WEIGHT_BITS-1:0];
    end else if (upd < W_LO) begin
      upd_sat = W_LO[WEIGHT_BITS-1:0];
    end else begin
      upd_sat = upd[WEIGHT_BITS-1:0];
    end
  end

  assign wr_ok  = s1_valid_q && is_wcmd && (s1_idx_q <= BIAS_IDX);
  assign acc_ok = (s1_idx_q < BIAS_IDX) && (CMP_W'(s1_idx_q) < CMP_W'(attr_used_i));

  assign ram_we_o    = en_i && wr_ok && !is_bias;
  assign ram_waddr_o = s1_idx_q[ADDR_W-1:0];
  assign ram_wdata_o = upd_sat;

  always_comb begin
    s2_ctrl_d.valid = s1_valid_q && (s1_cmd_q == CMD_CLASSIFY);
    s2_ctrl_d.acc   = acc_ok;
    s2_ctrl_d.last  = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      valid_q    <= '0;
      bias_q     <= '0;
      s2_ctrl_q  <= '0;
    end else if (en_i) begin
      s1_valid_q <= req_valid_i;
      fwd_hit_q  <= ram_we_o && (ram_waddr_o == ram_raddr_o);
      rd_vld_q   <= rd_in_range ? valid_q[ram_raddr_o] : 1'b0;
      if (ram_we_o) begin
        valid_q[ram_waddr_o] <= 1'b1;
      end
      if (wr_ok && is_bias) begin
        bias_q <= upd_sat;
      end
      s2_ctrl_q <= s2_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cmd_q  <= req_cmd_i;
      s1_idx_q  <= req_idx_i;
      s1_val_q  <= req_val_i;
      s1_last_q <= req_last_i;
      fwd_q     <= upd_sat;
      s2_prod_q <= prod;
    end
  end

  assign bias_o    = bias_q;
  assign s2_ctrl_o = s2_ctrl_q;
  assign s2_prod_o = s2_prod_q;

  a_we_only_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> en_i)
    else $error("weight write while pipeline stalled");

  a_fwd_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_hit_q) |-> $past(ram_we_o))
    else $error("forwarded weight without a preceding write");

endmodule

### design/ltc_decide.sv
// Running sum accumulation, bias add, decision and result register.
module ltc_decide #(
  parameter int WEIGHT_BITS = ltc_pkg::WeightBitsDef,
  localparam int PROD_W = WEIGHT_BITS + ltc_pkg::VAL_W
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  ltc_pkg::acc_ctrl_t               ctrl_i,
  input  logic signed [PROD_W-1:0]         prod_i,
  input  logic signed [WEIGHT_BITS-1:0]    bias_i,
  output logic                             res_valid_o,
  output logic                             category_o,
  output logic signed [ltc_pkg::SCORE_W-1:0] score_o
);
  import ltc_pkg::*;

  localparam int SE_W = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
  localparam logic signed [SE_W-1:0] S_HI =
    {{(SE_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SE_W-1:0] S_LO = ~S_HI;
  localparam logic signed [SUM_W-1:0] SC_HI =
    {{(SUM_W - SCORE_W + 1){1'b0}}, {(SCORE_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SC_LO = ~SC_HI;

  logic signed [SUM_W-1:0]   run_q;
  logic                      res_valid_q;
  logic                      category_q;
  logic signed [SCORE_W-1:0] score_q;

  logic signed [SE_W-1:0]    sum_ext;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [SE_W-1:0]    tot_ext;
  logic signed [SUM_W-1:0]   tot_sat;
  logic signed [SCORE_W-1:0] score_d;

  assign sum_ext = SE_W'(run_q) + (ctrl_i.acc ? SE_W'(prod_i) : '0);

  always_comb begin
    if (sum_ext > S_HI) begin
      sum_sat = S_HI[SUM_W-1:0];
    end else if (sum_ext < S_LO) begin
      sum_sat = S_LO[SUM_W-1:0];
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // bias is Q8.8, the sum Q24.16
  assign tot_ext = SE_W'(sum_sat) + (SE_W'(bias_i) <<< 8);

  always_comb begin
    if (tot_ext > S_HI) begin
      tot_sat = S_HI[SUM_W-1:0];
    end else if (tot_ext < S_LO) begin
      tot_sat = S_LO[SUM_W-1:0];
    end else begin
      tot_sat = tot_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    if (tot_sat > SC_HI) begin
      score_d = SC_HI[SCORE_W-1:0];
    end else if (tot_sat < SC_LO) begin
      score_d = SC_LO[SCORE_W-1:0];
    end else begin
      score_d = tot_sat[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      res_valid_q <= 1'b0;
    end else if (en_i) begin
      res_valid_q <= ctrl_i.valid && ctrl_i.last;
      if (ctrl_i.valid) begin
        run_q <= ctrl_i.last ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.valid && ctrl_i.last) begin
      category_q <= !tot_sat[SUM_W-1];
      score_q    <= score_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign category_o  = category_q;
  assign score_o     = score_q;

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && ctrl_i.valid && ctrl_i.last) |=> (run_q == '0))
    else $error("running sum not cleared after decision");

  a_cat_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (category_q == !score_q[SCORE_W-1]))
    else $error("category disagrees with score sign");

endmodule

### design/linear_threshold_classifier_core.sv
// Top level of the linear threshold classifier.
//
//  port group     dir  content (lsb first)                      handshake
//  s_axis_*       in   tdata: element_index, operand_value      tvalid/tready
//                      tuser: cmd; tlast: last_element
//  m_axis_*       out  tdata: score; tuser: category            tvalid/tready
//  cfg_*          in   wdata: attributes_in_use                 we, no wait
//
//  One request per cycle while no result is held. Three register stages: weight read,
//  weight update / product, accumulate and result register.
//  Weight store reads and writes one entry per cycle; a write in stage 1
//  is forwarded to a read of the same entry in the same cycle.
//  Reset clears all weights (entry valid bits) and the running sum.
//  A held result stalls all stages together; tready drops only then.
module linear_threshold_classifier_core #(
  parameter int MAX_ATTR    = ltc_pkg::MaxAttrDef,
  parameter int WEIGHT_BITS = ltc_pkg::WeightBitsDef,
  localparam int IDX_W   = $clog2(MAX_ATTR + 1),
  localparam int TDATA_W = ((IDX_W + ltc_pkg::VAL_W + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [TDATA_W-1:0]            s_axis_tdata_i,  // element_index, operand_value, 0 pad
  input  logic [ltc_pkg::CMD_W-1:0]     s_axis_tuser_i,  // cmd
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ltc_pkg::SCORE_W-1:0]   m_axis_tdata_o,  // score
  output logic [0:0]                    m_axis_tuser_o,  // category
  input  logic                          cfg_we_i,
  input  logic [ltc_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import ltc_pkg::*;

  localparam int ADDR_W = (MAX_ATTR > 1) ? $clog2(MAX_ATTR) : 1;
  localparam int PROD_W = WEIGHT_BITS + VAL_W;

  logic [CFG_W-1:0]              attr_used_q;
  logic                          en;
  logic                          res_valid;
  logic                          category;
  logic signed [SCORE_W-1:0]     score;

  logic                          ram_re;
  logic [ADDR_W-1:0]             ram_raddr;
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [WEIGHT_BITS-1:0]        ram_wdata;
  logic [WEIGHT_BITS-1:0]        ram_rdata;
  logic signed [WEIGHT_BITS-1:0] bias;
  acc_ctrl_t                     s2_ctrl;
  logic signed [PROD_W-1:0]      s2_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_used_q <= ATTR_USED_RESET;
    end else if (cfg_we_i) begin
      attr_used_q <= cfg_wdata_i;
    end
  end

  assign en              = !res_valid || m_axis_tready_i;
  assign s_axis_tready_o = en;

  ltc_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_ATTR)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ltc_weight_unit #(
    .MAX_ATTR    (MAX_ATTR),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_weight_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .req_valid_i (s_axis_tvalid_i),
    .req_cmd_i   (cmd_e'(s_axis_tuser_i)),
    .req_idx_i   (s_axis_tdata_i[IDX_W-1:0]),
    .req_val_i   ($signed(s_axis_tdata_i[IDX_W +: VAL_W])),
    .req_last_i  (s_axis_tlast_i),
    .attr_used_i (attr_used_q),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .bias_o      (bias),
    .s2_ctrl_o   (s2_ctrl),
    .s2_prod_o   (s2_prod)
  );

  ltc_decide #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctrl_i      (s2_ctrl),
    .prod_i      (s2_prod),
    .bias_i      (bias),
    .res_valid_o (res_valid),
    .category_o  (category),
    .score_o     (score)
  );

  assign m_axis_tvalid_o   = res_valid;
  assign m_axis_tdata_o    = score;
  assign m_axis_tuser_o[0] = category;

endmodule

### verif/linear_threshold_classifier_core_tb.sv
// Self-checking testbench for the linear threshold classifier core.
`timescale 1ns / 1ps

module linear_threshold_classifier_core_tb;
  import ltc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [6:0]       idx;
    logic [VAL_W-1:0] val;
    logic             last;
  } req_t;

  typedef struct {
    logic               category;
    logic [SCORE_W-1:0] score;
  } verdict_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               s_valid = 1'b0;
  logic [23:0]        s_tdata = '0;
  logic [CMD_W-1:0]   s_tuser = '0;
  logic               s_tlast = 1'b0;
  logic               m_ready = 1'b0;
  logic               cfg_we  = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [SCORE_W-1:0] m_axis_tdata_o;
  logic [0:0]         m_axis_tuser_o;

  req_t     req_q[$];
  verdict_t verdict_q[$];
  req_t     bus_req;

  logic signed [WeightBitsDef-1:0] weight_tbl [0:MaxAttrDef];
  longint      acc_sum = 0;
  logic [CFG_W-1:0] attr_used = ATTR_USED_RESET;

  int n_pushed = 0;
  int n_accepted = 0;
  int n_err = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  linear_threshold_classifier_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(6_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // expected effect of one accepted request
  function automatic void apply_request(input req_t r);
    longint   w, v, p, total;
    int       used;
    verdict_t vd;
    used = (attr_used > MaxAttrDef) ? MaxAttrDef : int'(attr_used);
    v = longint'($signed(r.val));
    if (r.cmd == CMD_CLASSIFY) begin
      if (int'(r.idx) < used)
        acc_sum = clamp(acc_sum + longint'(weight_tbl[r.idx]) * v, SUM_W);
      if (r.last) begin
        total = clamp(acc_sum + longint'(weight_tbl[MaxAttrDef]) * 256, SUM_W);
        acc_sum = 0;
        vd.category = (total >= 0);
        vd.score = SCORE_W'(clamp(total, SCORE_W));
        verdict_q.push_back(vd);
      end
    end else if (r.cmd <= CMD_MUL && int'(r.idx) <= MaxAttrDef) begin
      w = longint'(weight_tbl[r.idx]);
      case (r.cmd)
        CMD_SET: p = v;
        CMD_ADD: p = w + v;
        CMD_SUB: p = w - v;
        default: p = (w * v) >>> 8;
      endcase
      weight_tbl[r.idx] = WeightBitsDef'(clamp(p, WeightBitsDef));
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        apply_request(bus_req);
        n_accepted++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_req = req_q.pop_front();
          s_valid <= 1'b1;
          s_tdata <= {1'b0, bus_req.val, bus_req.idx};
          s_tuser <= bus_req.cmd;
          s_tlast <= bus_req.last;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    verdict_t vd;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (verdict_q.size() == 0) begin
          if (n_err < 10)
            $display("unexpected result: category %0d score %0d",
                     m_axis_tuser_o, $signed(m_axis_tdata_o));
          n_err++;
        end else begin
          vd = verdict_q.pop_front();
          if (vd.category !== m_axis_tuser_o[0] || vd.score !== m_axis_tdata_o) begin
            if (n_err < 10)
              $display("mismatch: exp category %0d score %0d, got category %0d score %0d",
                       vd.category, $signed(vd.score), m_axis_tuser_o,
                       $signed(m_axis_tdata_o));
            n_err++;
          end
        end
      end
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push(input logic [CMD_W-1:0] cmd, input int idx, input logic [15:0] val,
                      input logic last);
    req_t r;
    r.cmd = cmd;
    r.idx = 7'(idx);
    r.val = val;
    r.last = last;
    req_q.push_back(r);
    n_pushed++;
  endtask

  // wait until every request is in and every result out, then let the pipe empty
  task automatic drain();
    while (n_accepted != n_pushed || verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_attr_count(input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    attr_used = v;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic gen_block(input int target);
    int made, k, len;
    made = 0;
    while (made < target) begin
      k = $urandom_range(99);
      if (k < 22) begin
        push(CMD_W'(CMD_SET + $urandom_range(3)),
             ($urandom_range(9) == 0) ? $urandom_range(65, 127) : $urandom_range(64),
             pick_value(), 1'($urandom_range(1)));
        made++;
      end else if (k < 27) begin
        push(CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI)), $urandom_range(127),
             16'($urandom), 1'($urandom_range(1)));
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          push(CMD_CLASSIFY,
               ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(63),
               pick_value(),
               (j == len - 1) && ($urandom_range(19) != 0));
          made++;
        end
      end
    end
  endtask

  initial begin
    static logic [CFG_W-1:0] cfg_list [9] = '{7'd1, 7'd127, 7'd37, 7'd0, 7'd64, 7'd20,
                                              7'd65, 7'd5, 7'd64};
    for (int i = 0; i <= MaxAttrDef; i++) weight_tbl[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 14;
    recv_idle_pct = 88;
    push(CMD_CLASSIFY, 0, 16'h1234, 1'b1);
    push(CMD_SET, 0, 16'h7FFF, 1'b0);
    push(CMD_SET, MaxAttrDef, 16'h8000, 1'b1);
    push(CMD_SET, 1, 16'hFFFF, 1'b0);
    push(CMD_CLASSIFY, 0, 16'h7FFF, 1'b0);
    push(CMD_CLASSIFY, 1, 16'h8000, 1'b0);
    push(CMD_CLASSIFY, 70, 16'h7FFF, 1'b1);
    push(CMD_ADD, 0, 16'h7FFF, 1'b0);
    push(CMD_SUB, MaxAttrDef, 16'h7FFF, 1'b0);
    push(CMD_MUL, 1, 16'h8000, 1'b0);
    push(CMD_SET, 2, 16'h0003, 1'b0);
    push(CMD_MUL, 2, 16'hFFFF, 1'b0);
    push(CMD_ADD, 100, 16'h0001, 1'b0);
    push(CMD_UNDEF_LO, 3, 16'h7FFF, 1'b1);
    push(CMD_UNDEF_HI, MaxAttrDef, 16'h8000, 1'b1);
    // hold the sender until the pipe has run dry
    drain();
    for (int j = 0; j < 3; j++) push(CMD_CLASSIFY, 0, 16'h7FFF, 1'b0);
    push(CMD_CLASSIFY, 2, 16'h0000, 1'b1);
    for (int j = 0; j < 3; j++) push(CMD_CLASSIFY, 0, 16'h8000, 1'b0);
    push(CMD_CLASSIFY, MaxAttrDef, 16'h8000, 1'b1);
    push(CMD_CLASSIFY, 0, 16'h0000, 1'b1);
    push(CMD_SUB, MaxAttrDef, 16'h8000, 1'b0);
    drain();

    for (int b = 0; b < 9; b++) begin
      case (b / 3)
        0: begin send_idle_pct = 14; recv_idle_pct = 88; end
        1: begin send_idle_pct = 88; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_attr_count(cfg_list[b]);
      gen_block(181);
      drain();
    end

    if (n_err == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
